// File: hw/rtl/process_table_fifo_lifo_scheduler_unit_defines.svh
// Assertion macros shared by the process table scheduler RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PROCESS_TABLE_FIFO_LIFO_SCHEDULER_UNIT_DEFINES_SVH
`define PROCESS_TABLE_FIFO_LIFO_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PTFLS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PTFLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ptfls_pkg.sv
// Package for the process table scheduler: sizes, codes and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package ptfls_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int PID_W = 16;
  localparam int OP_W  = 2;
  localparam int POL_W = 2;

  // Event codes.
  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_END   = 2'd1;
  localparam logic [OP_W-1:0] OP_SCHED = 2'd2;

  // Scheduling policies.
  localparam logic [POL_W-1:0] POL_ANY   = 2'd0;
  localparam logic [POL_W-1:0] POL_FIFO  = 2'd1;
  localparam logic [POL_W-1:0] POL_LIFO  = 2'd2;
  localparam logic [POL_W-1:0] POL_RESET = POL_LIFO;

  typedef struct packed {
    logic load;       // latch the accepted item and clear the scan state
    logic slot_step;  // test one slot of the table and advance
    logic list_step;  // test one list entry, remove it on a match
    logic list_sel;   // 0 selects the arrival queue, 1 the stack
    logic scan_clr;   // restart the scan index
    logic fifo_take;  // read the queue head and mark it for removal
    logic lifo_take;  // read the stack top
    logic emit;       // move the result into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [POL_W-1:0] policy;
    logic             slot_hit;
    logic             slot_last;
    logic             list_hit;
    logic             list_last;
    logic             queue_empty;
  } dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/ptfls_dp.sv
// Datapath of the process table scheduler: slot table, queue, stack, scan
// index and result registers. Depends on ptfls_pkg and the defines header.
`default_nettype none

`include "process_table_fifo_lifo_scheduler_unit_defines.svh"

module ptfls_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [ptfls_pkg::POL_W-1:0]  cfg_wdata,
  input  wire logic [ptfls_pkg::OP_W-1:0]   opcode,
  input  wire logic [ptfls_pkg::PID_W-1:0]  pid,
  input  wire ptfls_pkg::dp_cmd_t           cmd,
  output ptfls_pkg::dp_status_t             status,
  output logic                              ok,
  output logic [ptfls_pkg::PID_W-1:0]       chosen_pid
);

  localparam int SLOTS = ptfls_pkg::SLOTS;
  localparam int IDX_W = ptfls_pkg::IDX_W;
  localparam int CNT_W = ptfls_pkg::CNT_W;
  localparam int PID_W = ptfls_pkg::PID_W;
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  logic [ptfls_pkg::POL_W-1:0] policy;
  logic [ptfls_pkg::OP_W-1:0]  op_r;
  logic [PID_W-1:0]            pid_r;
  logic [SLOTS-1:0]            slot_valid;
  logic [PID_W-1:0]            slot_pid [SLOTS];
  logic [IDX_W-1:0]            queue [SLOTS];
  logic [IDX_W-1:0]            stack [SLOTS];
  logic [CNT_W-1:0]            qcount;
  logic [CNT_W-1:0]            scount;
  logic [IDX_W-1:0]            idx;
  logic [IDX_W-1:0]            tgt;
  logic                        res_ok;
  logic [PID_W-1:0]            res_pid;

  logic [CNT_W-1:0] stop_pos;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_valid;
  logic [PID_W-1:0] rd_pid;
  logic             slot_hit;
  logic [CNT_W-1:0] lcount;
  logic [IDX_W-1:0] lentry;
  logic [CNT_W-1:0] idx_ext;
  logic             list_hit;
  logic             list_last;
  logic             push_q;
  logic             push_s;

  // One read port into the slot table, shared by the scan and the list heads.
  always_comb begin
    stop_pos = scount - CNT_W'(1);
    priority if (cmd.fifo_take) begin
      rd_addr = queue[0];
    end else if (cmd.lifo_take) begin
      rd_addr = stack[stop_pos[IDX_W-1:0]];
    end else begin
      rd_addr = idx;
    end
    rd_valid = slot_valid[rd_addr];
    rd_pid   = slot_pid[rd_addr];
  end

  always_comb begin
    unique case (op_r)
      ptfls_pkg::OP_START: slot_hit = !rd_valid;
      ptfls_pkg::OP_END:   slot_hit = rd_valid && (rd_pid == pid_r);
      ptfls_pkg::OP_SCHED: slot_hit = rd_valid;
      default:             slot_hit = 1'b0;
    endcase
  end

  always_comb begin
    lcount    = cmd.list_sel ? scount : qcount;
    lentry    = cmd.list_sel ? stack[idx] : queue[idx];
    idx_ext   = CNT_W'(idx);
    list_hit  = (idx_ext < lcount) && (lentry == tgt);
    list_last = (idx_ext + CNT_W'(1)) >= lcount;
  end

  assign push_q = cmd.slot_step && slot_hit && (op_r == ptfls_pkg::OP_START) &&
                  (qcount < SLOTS_C);
  assign push_s = cmd.slot_step && slot_hit && (op_r == ptfls_pkg::OP_START) &&
                  (scount < SLOTS_C);

  always_comb begin
    status.op          = op_r;
    status.policy      = policy;
    status.slot_hit    = slot_hit;
    status.slot_last   = (idx == LAST_IDX);
    status.list_hit    = list_hit;
    status.list_last   = list_last;
    status.queue_empty = (qcount == '0);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      policy     <= ptfls_pkg::POL_RESET;
      slot_valid <= '0;
      qcount     <= '0;
      scount     <= '0;
    end else begin
      if (cfg_we) begin
        policy <= cfg_wdata;
      end
      if (cmd.slot_step && slot_hit) begin
        if (op_r == ptfls_pkg::OP_START) begin
          slot_valid[idx] <= 1'b1;
        end else if (op_r == ptfls_pkg::OP_END) begin
          slot_valid[idx] <= 1'b0;
        end
      end
      if (push_q) begin
        qcount <= qcount + CNT_W'(1);
      end
      if (push_s) begin
        scount <= scount + CNT_W'(1);
      end
      if (cmd.list_step && list_hit) begin
        if (cmd.list_sel) begin
          scount <= scount - CNT_W'(1);
        end else begin
          qcount <= qcount - CNT_W'(1);
        end
      end
    end
  end

  // Scan index; cleared by command, so no reset needed here.
  always_ff @(posedge clk) begin
    if (cmd.load || cmd.scan_clr) begin
      idx <= '0;
    end else if (cmd.slot_step || cmd.list_step) begin
      idx <= idx + IDX_W'(1);
    end
  end

  // Payload storage.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= opcode;
      pid_r   <= pid;
      res_ok  <= 1'b0;
      res_pid <= '0;
    end
    if (cmd.slot_step && slot_hit) begin
      res_ok <= 1'b1;
      if (op_r == ptfls_pkg::OP_START) begin
        slot_pid[idx] <= pid_r;
      end
      if (op_r == ptfls_pkg::OP_END) begin
        tgt <= idx;
      end
      if (op_r == ptfls_pkg::OP_SCHED) begin
        res_pid <= rd_pid;
      end
    end
    if (push_q) begin
      queue[qcount[IDX_W-1:0]] <= idx;
    end
    if (push_s) begin
      stack[scount[IDX_W-1:0]] <= idx;
    end
    if (cmd.fifo_take) begin
      tgt     <= queue[0];
      res_ok  <= rd_valid;
      res_pid <= rd_valid ? rd_pid : '0;
    end
    if (cmd.lifo_take && (scount != '0)) begin
      res_ok  <= rd_valid;
      res_pid <= rd_valid ? rd_pid : '0;
    end
    // Removal closes the gap: every entry at or above the match moves down.
    if (cmd.list_step && list_hit) begin
      for (int i = 0; i < SLOTS - 1; i++) begin
        if (IDX_W'(i) >= idx) begin
          if (cmd.list_sel) begin
            stack[i] <= stack[i + 1];
          end else begin
            queue[i] <= queue[i + 1];
          end
        end
      end
    end
    if (cmd.emit) begin
      ok         <= res_ok;
      chosen_pid <= res_pid;
    end
  end

  `PTFLS_ASSERT_IMPL(a_qcount_range, clk, rst, 1'b1, qcount <= SLOTS_C, "queue count overflow")
  `PTFLS_ASSERT_IMPL(a_scount_range, clk, rst, 1'b1, scount <= SLOTS_C, "stack count overflow")
  `PTFLS_ASSERT_NEXT(a_queue_shrinks, clk, rst, cmd.list_step && !cmd.list_sel && list_hit, qcount == $past(qcount) - CNT_W'(1), "queue removal did not shrink count")

endmodule

`default_nettype wire

// File: hw/rtl/ptfls_ctrl.sv
// Controller of the process table scheduler: sequences the slot scan and the
// list removals and owns both handshakes. Needs ptfls_pkg and the defines header.
`default_nettype none

`include "process_table_fifo_lifo_scheduler_unit_defines.svh"

module ptfls_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  input  wire ptfls_pkg::dp_status_t  status,
  output ptfls_pkg::dp_cmd_t          cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SLOT_SCAN,
    S_FIFO,
    S_LIFO,
    S_QUEUE_RM,
    S_STACK_RM,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status.op)
          ptfls_pkg::OP_START, ptfls_pkg::OP_END: state_next = S_SLOT_SCAN;
          ptfls_pkg::OP_SCHED: begin
            unique case (status.policy)
              ptfls_pkg::POL_ANY:  state_next = S_SLOT_SCAN;
              ptfls_pkg::POL_FIFO: state_next = status.queue_empty ? S_DONE : S_FIFO;
              ptfls_pkg::POL_LIFO: state_next = S_LIFO;
              default:             state_next = S_DONE;
            endcase
          end
          default: state_next = S_DONE;
        endcase
      end
      S_SLOT_SCAN: begin
        cmd.slot_step = 1'b1;
        if (status.slot_hit && (status.op == ptfls_pkg::OP_END)) begin
          cmd.scan_clr = 1'b1;
          state_next   = S_QUEUE_RM;
        end else if (status.slot_hit || status.slot_last) begin
          state_next = S_DONE;
        end
      end
      S_FIFO: begin
        cmd.fifo_take = 1'b1;
        cmd.scan_clr  = 1'b1;
        state_next    = S_QUEUE_RM;
      end
      S_LIFO: begin
        cmd.lifo_take = 1'b1;
        state_next    = S_DONE;
      end
      S_QUEUE_RM: begin
        cmd.list_step = 1'b1;
        if (status.list_hit || status.list_last) begin
          cmd.scan_clr = 1'b1;
          state_next   = S_STACK_RM;
        end
      end
      S_STACK_RM: begin
        cmd.list_step = 1'b1;
        cmd.list_sel  = 1'b1;
        if (status.list_hit || status.list_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `PTFLS_ASSERT_IMPL(a_emit_when_free, clk, rst, cmd.emit, !out_valid || !out_stall, "result overwrote a waiting item")
  `PTFLS_ASSERT_NEXT(a_load_decodes, clk, rst, cmd.load, state == S_DECODE, "accepted item not decoded")
  `PTFLS_ASSERT_NEXT(a_emit_shows, clk, rst, cmd.emit, out_valid && state == S_IDLE, "emitted result not presented")

endmodule

`default_nettype wire

// File: hw/rtl/process_table_fifo_lifo_scheduler_unit.sv
// Top level of the process table scheduler: controller plus datapath.
// Depends on ptfls_pkg, ptfls_ctrl and ptfls_dp.
//
// Usage. Input items (opcode, pid) arrive on in_valid / in_stall and results
// (ok, chosen_pid) leave on out_valid / out_stall; an item moves at a clock
// edge where valid is high and stall is low. Every input item yields exactly
// one result item. The policy register is written through cfg_we / cfg_wdata
// by the user, only while the block is idle; the block does not enforce this.
// One item is worked on at a time; in_stall is high from acceptance until its
// result is in the output register; then the next item can be taken.
// Scans walk one slot or list entry per cycle. After decode, a start, an end
// or a lowest-slot schedule scans the slots up to the first hit or the last
// slot; an end with a match then removes the slot index from the queue and
// then from the stack. A fifo schedule takes the queue head and removes it
// from both lists, a lifo schedule reads the stack top, and an empty fifo or
// a spare code goes straight from decode to the done state.
// If the receiver stalls, the result holds and a finished second item waits
// in the controller until the output register frees.
// Reset clears the slot valid bits, both list counts and the handshakes and
// sets the policy to lifo; no clearing pass is needed.
`default_nettype none

module process_table_fifo_lifo_scheduler_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [ptfls_pkg::OP_W-1:0]   opcode,
  input  wire logic [ptfls_pkg::PID_W-1:0]  pid,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              ok,
  output logic [ptfls_pkg::PID_W-1:0]       chosen_pid,
  input  wire logic                         cfg_we,
  input  wire logic [ptfls_pkg::POL_W-1:0]  cfg_wdata
);

  // Commands flow from the controller; status flows back from the datapath.
  ptfls_pkg::dp_cmd_t    cmd;
  ptfls_pkg::dp_status_t status;

  ptfls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ptfls_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .opcode     (opcode),
    .pid        (pid),
    .cmd        (cmd),
    .status     (status),
    .ok         (ok),
    .chosen_pid (chosen_pid)
  );

endmodule

`default_nettype wire
